@@ rtl/psk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_pkg
// Types, codes and sizes shared by the positional stack files.
// ----------------------------------------------------------------------------
package psk_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 5;
  localparam int ENTRY_W     = 5;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  // common width for comparing positions, indexes and counts
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_DELETE = 2'd3
  } psk_req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } psk_status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } psk_cell_op_e;

  // broadcast to every cell of the row
  typedef struct packed {
    psk_cell_op_e              op;
    logic [CMP_W-1:0]          pos;
    logic [CMP_W-1:0]          count;
    logic signed [VALUE_W-1:0] value;
    logic                      rd_en;
    logic [CMP_W-1:0]          rd_idx;
  } psk_cell_ctrl_t;

endpackage

@@ rtl/psk_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface psk_req_if;
  import psk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]          item_position;

  modport source (output valid, output req_type, output item_value, output item_position,
                  input ready);
  modport sink (input valid, input req_type, input item_value, input item_position,
                output ready);
endinterface

@@ rtl/psk_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface psk_rsp_if;
  import psk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [ENTRY_W-1:0]        entry_count;
  logic signed [VALUE_W-1:0] top_value;
  logic signed [VALUE_W-1:0] removed_value;

  modport source (output valid, output status, output entry_count, output top_value,
                  output removed_value, input ready);
  modport sink (input valid, input status, input entry_count, input top_value,
                input removed_value, output ready);
endinterface

@@ rtl/psk_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_cell
// One stack slot: holds an entry, takes a new value or a neighbor's value,
// and drives its entry on the read bus when addressed.
// ----------------------------------------------------------------------------
module psk_cell (
  input  logic                              clk,
  input  logic [psk_pkg::IDX_W-1:0]         idx,
  input  psk_pkg::psk_cell_ctrl_t           ctrl,
  input  logic signed [psk_pkg::VALUE_W-1:0] below,
  input  logic signed [psk_pkg::VALUE_W-1:0] above,
  output logic signed [psk_pkg::VALUE_W-1:0] value,
  output logic signed [psk_pkg::VALUE_W-1:0] rd_data
);
  import psk_pkg::*;

  logic [CMP_W-1:0]          my_idx;
  logic signed [VALUE_W-1:0] value_next;

  assign my_idx = CMP_W'(idx);

  always_comb begin
    value_next = value;
    case (ctrl.op)
      CELL_INS: begin
        if (my_idx == ctrl.pos) begin
          value_next = ctrl.value;
        end else if (my_idx > ctrl.pos && my_idx <= ctrl.count) begin
          value_next = below;
        end
      end
      CELL_DEL: begin
        // entries above the hole slide down
        if (my_idx >= ctrl.pos && (my_idx + CMP_W'(1)) < ctrl.count) begin
          value_next = above;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign rd_data = (ctrl.rd_en && my_idx == ctrl.rd_idx) ? value : '0;

endmodule

@@ rtl/positional_stack_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_stack_core
// Bounded stack with push, pop, insert at position and delete at position.
// ----------------------------------------------------------------------------
// The stack is a row of STACK_DEPTH cells, one entry each, positions counted
// from the bottom. In the cycle the request beat is accepted all cells shift
// up or down at once and the removed entry is read off the row; in S_FIN the
// new top entry is read off the row and the result goes into the output
// register once that register is free. A new request beat is taken only once
// that result is loaded, so the block works on one request at a time.
// Entries hold no reset value; only entries below the count are ever read.
module positional_stack_core (
  input logic      clk,
  input logic      rst,
  psk_req_if.sink  req,
  psk_rsp_if.source rsp
);
  import psk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIN  = 2'b10
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  psk_status_e               status_next;
  psk_status_e               stat;
  logic signed [VALUE_W-1:0] removed;
  psk_cell_ctrl_t            ctrl;
  logic                      acc;
  logic                      load;
  logic [CMP_W-1:0]          cnt_c;
  logic [CMP_W-1:0]          pos_c;
  logic [CMP_W-1:0]          depth_c;
  logic signed [VALUE_W-1:0] rd_or;

  logic signed [VALUE_W-1:0] cell_val [STACK_DEPTH];
  logic signed [VALUE_W-1:0] cell_rd  [STACK_DEPTH];

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign load      = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign cnt_c   = CMP_W'(count);
  assign pos_c   = CMP_W'(req.item_position);
  assign depth_c = CMP_W'(STACK_DEPTH);

  // request decode and cell control
  always_comb begin
    ctrl        = '0;
    ctrl.op     = CELL_HOLD;
    ctrl.count  = cnt_c;
    ctrl.value  = req.item_value;
    ctrl.pos    = pos_c;
    count_next  = count;
    status_next = ST_OK;
    if (state == S_IDLE) begin
      case (psk_req_e'(req.req_type))
        REQ_PUSH: begin
          if (cnt_c == depth_c) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_INS;
            ctrl.pos   = cnt_c;
            count_next = count + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.rd_en  = 1'b1;
            ctrl.rd_idx = cnt_c - CMP_W'(1);
            count_next  = count - CNT_W'(1);
          end
        end
        REQ_INSERT: begin
          if (cnt_c == depth_c) begin
            status_next = ST_FULL;
          end else if (pos_c > cnt_c) begin
            status_next = ST_BADPOS;
          end else begin
            ctrl.op    = CELL_INS;
            count_next = count + CNT_W'(1);
          end
        end
        REQ_DELETE: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else if (pos_c >= cnt_c) begin
            status_next = ST_BADPOS;
          end else begin
            ctrl.op     = CELL_DEL;
            ctrl.rd_en  = 1'b1;
            ctrl.rd_idx = pos_c;
            count_next  = count - CNT_W'(1);
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
      if (!acc) begin
        ctrl.op    = CELL_HOLD;
        ctrl.rd_en = 1'b0;
      end
    end else begin
      // S_FIN: read the new top entry
      ctrl.rd_en  = (count != '0);
      ctrl.rd_idx = cnt_c - CMP_W'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] below_val;
      logic signed [VALUE_W-1:0] above_val;
      if (g == 0) begin : g_bot
        assign below_val = '0;
      end else begin : g_mid_lo
        assign below_val = cell_val[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_top
        assign above_val = '0;
      end else begin : g_mid_hi
        assign above_val = cell_val[g+1];
      end
      psk_cell u_cell (
        .clk     (clk),
        .idx     (IDX_W'(g)),
        .ctrl    (ctrl),
        .below   (below_val),
        .above   (above_val),
        .value   (cell_val[g]),
        .rd_data (cell_rd[g])
      );
    end
  endgenerate

  // at most one cell drives the read bus
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_FIN;
            count <= count_next;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      stat    <= status_next;
      removed <= rd_or;
    end
    if (load) begin
      rsp.status        <= stat;
      rsp.entry_count   <= cnt_c[ENTRY_W-1:0];
      rsp.top_value     <= rd_or;
      rsp.removed_value <= removed;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_stack_core testbench
// Drives push, pop, insert and delete requests through the request channel.
// Each accepted request is run through a shadow stack in the bench, and every
// response beat is compared field by field with the oldest expected result.
// The run is split into phases with and without idle cycles on either side.
// ----------------------------------------------------------------------------
module testbench;
  import psk_pkg::*;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 8;

  typedef struct packed {
    psk_req_e                  kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } request_t;

  typedef struct packed {
    psk_status_e               status;
    logic [ENTRY_W-1:0]        count;
    logic signed [VALUE_W-1:0] top;
    logic signed [VALUE_W-1:0] removed;
  } stack_result_t;

  logic clk;
  logic rst;

  psk_req_if req_ch ();
  psk_rsp_if rsp_ch ();

  positional_stack_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t      pending_requests[$];
  stack_result_t expected_results[$];

  logic signed [VALUE_W-1:0] shadow_entries[STACK_DEPTH];
  int shadow_count;

  // count as seen by the stimulus builder, used to steer positions into range
  int gen_count;
  bit grow_mode;

  int send_idle_pct;
  int recv_stall_pct;
  bit req_fire;
  int mismatches;
  int cycle_count;
  request_t next_req;
  stack_result_t got;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic stack_result_t stack_apply(request_t r);
    stack_result_t res;
    res.status  = ST_OK;
    res.removed = '0;
    case (r.kind)
      REQ_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = r.value;
          shadow_count++;
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count--;
          res.removed = shadow_entries[shadow_count];
        end
      end
      REQ_INSERT: begin
        if (shadow_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else if (int'(r.pos) > shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = shadow_count; i > int'(r.pos); i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[r.pos] = r.value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(r.pos) >= shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.removed = shadow_entries[r.pos];
          for (int i = int'(r.pos); i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
    endcase
    res.count = ENTRY_W'(shadow_count);
    res.top   = (shadow_count == 0) ? '0 : shadow_entries[shadow_count-1];
    return res;
  endfunction

  function automatic void queue_request(request_t r);
    pending_requests.push_back(r);
    case (r.kind)
      REQ_PUSH:   if (gen_count < STACK_DEPTH) gen_count++;
      REQ_POP:    if (gen_count > 0) gen_count--;
      REQ_INSERT: if (gen_count < STACK_DEPTH && int'(r.pos) <= gen_count) gen_count++;
      default:    if (gen_count > 0 && int'(r.pos) < gen_count) gen_count--;
    endcase
    // linger a little at full and empty so the edge statuses get hit
    if (gen_count == STACK_DEPTH && $urandom_range(3) == 0) grow_mode = 1'b0;
    if (gen_count == 0 && $urandom_range(3) == 0) grow_mode = 1'b1;
    if ($urandom_range(99) < 2) grow_mode = !grow_mode;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int roll;
    roll = $urandom_range(99);
    if (grow_mode)
      r.kind = (roll < 40) ? REQ_PUSH : (roll < 75) ? REQ_INSERT :
               (roll < 90) ? REQ_POP : REQ_DELETE;
    else
      r.kind = (roll < 40) ? REQ_POP : (roll < 75) ? REQ_DELETE :
               (roll < 90) ? REQ_PUSH : REQ_INSERT;
    case ($urandom_range(9))
      0:       r.value = 32'sh8000_0000;
      1:       r.value = 32'sh7fff_ffff;
      2:       r.value = -32'sd1;
      3:       r.value = '0;
      default: r.value = $urandom;
    endcase
    if ($urandom_range(99) < 12 || r.kind == REQ_PUSH || r.kind == REQ_POP)
      r.pos = POS_W'($urandom_range(31, 0));
    else if (r.kind == REQ_INSERT)
      r.pos = POS_W'($urandom_range(gen_count, 0));
    else
      r.pos = (gen_count > 0) ? POS_W'($urandom_range(gen_count - 1, 0)) : '0;
    return r;
  endfunction

  // request driver: fields change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      req_fire = 1'b0;
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= next_req.kind;
        req_ch.item_value    <= next_req.value;
        req_ch.item_position <= next_req.pos;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst)
      rsp_ch.ready <= 1'b0;
    else
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // request and response beats are both sampled on the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("positional_stack_core test failed");
      $finish;
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      req_fire = 1'b1;
      expected_results.push_back(stack_apply('{psk_req_e'(req_ch.req_type),
                                               req_ch.item_value,
                                               req_ch.item_position}));
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response beat: status %0d count %0d top %0d removed %0d",
                   rsp_ch.status, rsp_ch.entry_count, rsp_ch.top_value,
                   rsp_ch.removed_value);
        mismatches++;
      end else begin
        got = expected_results.pop_front();
        if (rsp_ch.status !== got.status || rsp_ch.entry_count !== got.count ||
            rsp_ch.top_value !== got.top || rsp_ch.removed_value !== got.removed) begin
          if (mismatches < 10)
            $display("mismatch at cycle %0d: exp status %s count %0d top %0d removed %0d,",
                     cycle_count, got.status.name(), got.count, got.top, got.removed,
                     " got status %0d count %0d top %0d removed %0d",
                     rsp_ch.status, rsp_ch.entry_count, rsp_ch.top_value,
                     rsp_ch.removed_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    req_fire             = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_PUSH;
    req_ch.item_value    = '0;
    req_ch.item_position = '0;
    rsp_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    mismatches           = 0;
    cycle_count          = 0;
    shadow_count         = 0;
    gen_count            = 0;
    grow_mode            = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (phase == 0) begin
        // empty stack and out-of-range positions first, then shifting in the middle
        queue_request('{REQ_POP,    32'sd0,          5'd0});
        queue_request('{REQ_DELETE, 32'sd0,          5'd0});
        queue_request('{REQ_INSERT, 32'sd5,          5'd1});
        queue_request('{REQ_INSERT, 32'sh8000_0000,  5'd0});
        queue_request('{REQ_PUSH,   32'sh7fff_ffff,  5'd31});
        queue_request('{REQ_PUSH,   -32'sd1,         5'd0});
        queue_request('{REQ_INSERT, 32'sd0,          5'd3});
        queue_request('{REQ_INSERT, 32'sh5a5a_5a5a,  5'd1});
        queue_request('{REQ_INSERT, 32'sh0123_4567,  5'd0});
        queue_request('{REQ_DELETE, 32'sd0,          5'd5});
        queue_request('{REQ_DELETE, 32'sd0,          5'd6});
        queue_request('{REQ_DELETE, -32'sd1,         5'd31});
        queue_request('{REQ_INSERT, 32'sd9,          5'd31});
        queue_request('{REQ_DELETE, 32'sd0,          5'd4});
        queue_request('{REQ_DELETE, 32'sd0,          5'd0});
        queue_request('{REQ_DELETE, 32'sd0,          5'd1});
        queue_request('{REQ_POP,    32'sd0,          5'd16});
        queue_request('{REQ_POP,    32'sd0,          5'd0});
        queue_request('{REQ_POP,    32'sd0,          5'd0});
      end
      repeat (RANDOM_PER_PHASE) queue_request(random_request());
      // hold off new beats until the block has answered everything
      while (pending_requests.size() > 0 || req_ch.valid || expected_results.size() > 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("positional_stack_core test passed");
    else
      $display("positional_stack_core test failed");
    $finish;
  end

endmodule
